FILE: hw/rtl/rdc_pkg.sv
// Package for the radix digit converter.
// Holds widths, character codes, the controller/datapath interface structs
// and the digit-to-ASCII function. No dependencies.
package rdc_pkg;

    localparam int RDC_MAX_DIGITS   = 64;
    localparam int RDC_VALUE_W      = 64;
    localparam int RDC_RADIX_W      = 6;
    localparam int RDC_CHAR_W       = 8;
    localparam int RDC_HIGHEST_BASE = 36;
    localparam int RDC_LOWEST_BASE  = 2;
    localparam int RDC_RADIX_RESET  = 16;

    // Divider: quotient register width and bits retired per cycle
    localparam int RDC_MAG_W         = 64;
    localparam int RDC_BITS_PER_STEP = 8;
    localparam int RDC_DIV_STEPS     = RDC_MAG_W / RDC_BITS_PER_STEP;
    localparam int RDC_STEP_W        = $clog2(RDC_DIV_STEPS);

    localparam logic [RDC_CHAR_W-1:0]  RDC_CHAR_ZERO  = 8'h30;
    localparam logic [RDC_CHAR_W-1:0]  RDC_CHAR_A     = 8'h41;
    localparam logic [RDC_CHAR_W-1:0]  RDC_CHAR_MINUS = 8'h2D;
    localparam logic [RDC_RADIX_W-1:0] RDC_DIGIT_TEN  = 6'd10;

    typedef struct packed {
        logic load;
        logic div;
        logic digit_end;
        logic prep;
        logic emit;
    } rdc_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic ptr_zero;
    } rdc_status_t;

    function automatic logic [RDC_CHAR_W-1:0] digit_char(input logic [RDC_RADIX_W-1:0] d);
        logic [RDC_CHAR_W-1:0] d_ext;
        d_ext = {{(RDC_CHAR_W-RDC_RADIX_W){1'b0}}, d};
        if (d < RDC_DIGIT_TEN)
            digit_char = RDC_CHAR_ZERO + d_ext;
        else
            digit_char = RDC_CHAR_A + d_ext - {{(RDC_CHAR_W-RDC_RADIX_W){1'b0}}, RDC_DIGIT_TEN};
    endfunction

endpackage

FILE: hw/rtl/radix_digit_converter.sv
// Top level of the radix digit converter.
// Joins the controller (rdc_ctrl) and the datapath (rdc_datapath).
// Depends on rdc_pkg.
//
// Usage:
//   Write the base (2..36, saturated outside) on cfg_data with cfg_valid;
//   cfg_ready is high only while busy is low. Reset base: 16.
//   Start a transaction by raising start with value while busy is low.
//   busy stays high until the last character has been shown.
//   Characters come out most significant first, one per cycle, each on
//   character for one cycle with strobe high; last_char marks the final one.
//   A negative value gives a leading '-'.
// Sequence, for a result of D digits: the divider works out each digit
//   (8 quotient bits per cycle over a 64-bit word), then a step that shows
//   '-' for negative values, then the D digits from the digit memory, one
//   read per cycle.
// Reset clears the controller and restores the base to 16. The receiver
// cannot stall: every strobed character is taken in its cycle.
module radix_digit_converter #(
    parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rdc_pkg::RDC_VALUE_W-1:0] value,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rdc_pkg::RDC_RADIX_W-1:0]        cfg_data,
    output logic                                   strobe,
    output logic [rdc_pkg::RDC_CHAR_W-1:0]         character,
    output logic                                   last_char
);
    import rdc_pkg::*;

    rdc_cmd_t    cmd;
    rdc_status_t status;
    logic        ctrl_busy;

    assign cfg_ready = !ctrl_busy;
    assign busy      = ctrl_busy;

    rdc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (ctrl_busy)
    );

    rdc_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char)
    );

endmodule

FILE: hw/rtl/rdc_ctrl.sv
// Controller state machine for the radix digit converter.
// Sequences load, digit division, sign and digit emission.
// Depends on rdc_pkg.
module rdc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rdc_pkg::rdc_status_t status,
    output rdc_pkg::rdc_cmd_t    cmd,
    output logic                 busy
);
    import rdc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [RDC_STEP_W-1:0] LAST_STEP = RDC_STEP_W'(RDC_DIV_STEPS - 1);

    logic [1:0]            state_reg, state_next;
    logic [RDC_STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div   = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    cmd.digit_end = 1'b1;
                    if (status.quot_zero)
                        state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.ptr_zero)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hw/rtl/rdc_datapath.sv
// Datapath for the radix digit converter: radix register, bit-serial
// divider (several bits a cycle), digit memory and character output.
// Depends on rdc_pkg.
module rdc_datapath #(
    parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rdc_pkg::rdc_cmd_t                    cmd,
    output rdc_pkg::rdc_status_t                 status,
    input  logic signed [rdc_pkg::RDC_VALUE_W-1:0] value,
    input  logic                                 cfg_we,
    input  logic [rdc_pkg::RDC_RADIX_W-1:0]      cfg_data,
    output logic                                 strobe,
    output logic [rdc_pkg::RDC_CHAR_W-1:0]       character,
    output logic                                 last_char
);
    import rdc_pkg::*;

    localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [RDC_VALUE_W-1:0] MOST_NEG = {1'b1, {(RDC_VALUE_W-1){1'b0}}};
    localparam logic [RDC_VALUE_W-1:0] MAX_MAG  = {1'b0, {(RDC_VALUE_W-1){1'b1}}};

    logic [RDC_RADIX_W-1:0] radix_reg;
    logic [RDC_MAG_W-1:0]   quot_reg;
    logic [RDC_RADIX_W-1:0] rem_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [ADDR_W-1:0]      ptr_reg;
    logic                   neg_reg;
    logic [RDC_RADIX_W-1:0] rd_data_reg;

    logic [RDC_RADIX_W-1:0] digit_mem [MAX_DIGITS];

    logic [RDC_RADIX_W-1:0] base;
    logic [RDC_VALUE_W-1:0] value_u;
    logic [RDC_VALUE_W-1:0] mag;
    logic [RDC_MAG_W-1:0]   quot_next;
    logic [RDC_RADIX_W-1:0] rem_next;
    logic [RDC_RADIX_W:0]   rem_ext;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [CNT_W-1:0]       count_dec;

    always_comb
    begin
        if (radix_reg < RDC_RADIX_W'(RDC_LOWEST_BASE))
            base = RDC_RADIX_W'(RDC_LOWEST_BASE);
        else if (radix_reg > RDC_RADIX_W'(RDC_HIGHEST_BASE))
            base = RDC_RADIX_W'(RDC_HIGHEST_BASE);
        else
            base = radix_reg;
    end

    // Clamp the most negative value, then take the magnitude
    always_comb
    begin
        value_u = value;
        if (!value_u[RDC_VALUE_W-1])
            mag = value_u;
        else if (value_u == MOST_NEG)
            mag = MAX_MAG;
        else
            mag = ~value_u + 1'b1;
    end

    // Restoring division, RDC_BITS_PER_STEP quotient bits per cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        rem_ext   = '0;
        for (int i = 0; i < RDC_BITS_PER_STEP; i++)
        begin
            rem_ext   = {rem_next, quot_next[RDC_MAG_W-1]};
            quot_next = {quot_next[RDC_MAG_W-2:0], 1'b0};
            if (rem_ext >= {1'b0, base})
            begin
                rem_ext      = rem_ext - {1'b0, base};
                quot_next[0] = 1'b1;
            end
            rem_next = rem_ext[RDC_RADIX_W-1:0];
        end
    end

    assign count_dec = count_reg - 1'b1;
    assign mem_we    = cmd.digit_end && (count_reg < CNT_W'(MAX_DIGITS));
    assign rd_addr   = cmd.prep ? count_dec[ADDR_W-1:0] : (ptr_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RDC_RADIX_W'(RDC_RADIX_RESET);
            quot_reg  <= '0;
            rem_reg   <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                radix_reg <= cfg_data;
            if (cmd.load)
            begin
                neg_reg   <= value_u[RDC_VALUE_W-1];
                quot_reg  <= {1'b0, mag[RDC_MAG_W-2:0]};
                rem_reg   <= '0;
                count_reg <= '0;
            end
            else if (cmd.div)
            begin
                quot_reg <= quot_next;
                if (cmd.digit_end)
                begin
                    rem_reg <= '0;
                    if (mem_we)
                        count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    rem_reg <= rem_next;
                end
            end
            if (cmd.prep)
                ptr_reg <= count_dec[ADDR_W-1:0];
            else if (cmd.emit)
                ptr_reg <= ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[ADDR_W-1:0]] <= rem_next;
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign status.quot_zero = (quot_next == '0);
    assign status.ptr_zero  = (ptr_reg == '0);

    assign strobe    = (cmd.prep && neg_reg) || cmd.emit;
    assign character = cmd.prep ? RDC_CHAR_MINUS : digit_char(rd_data_reg);
    assign last_char = cmd.emit && (ptr_reg == '0);

endmodule

FILE: tb/sv/rdc_char_checker.sv
`timescale 1ns / 1ps
// Checker for the radix digit converter: follows the config and command channels,
// predicts the character stream and compares every strobed character with it.
// Depends on rdc_pkg.
module rdc_char_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic signed [rdc_pkg::RDC_VALUE_W-1:0] value,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [rdc_pkg::RDC_RADIX_W-1:0]        cfg_data,
    input  logic                                   strobe,
    input  logic [rdc_pkg::RDC_CHAR_W-1:0]         character,
    input  logic                                   last_char,
    output int                                     outstanding,
    output int                                     fail_count
);
    import rdc_pkg::*;

    localparam int DECIMAL_DIGITS = 10;

    typedef struct {
        logic [RDC_CHAR_W-1:0] code;
        logic                  last;
    } char_t;

    char_t                  chars_due[$];
    logic [RDC_RADIX_W-1:0] radix_copy;

    function automatic void spell_value(input logic [RDC_VALUE_W-1:0] v,
                                        input logic [RDC_RADIX_W-1:0] reg_radix);
        logic [RDC_VALUE_W-1:0] mag;
        logic [RDC_VALUE_W-1:0] base;
        logic [RDC_VALUE_W-1:0] rem;
        logic [RDC_RADIX_W-1:0] digits [RDC_MAX_DIGITS];
        logic [RDC_CHAR_W-1:0]  d_ext;
        int                     count;
        char_t                  c;
        if (reg_radix < RDC_LOWEST_BASE)
            base = RDC_VALUE_W'(RDC_LOWEST_BASE);
        else if (reg_radix > RDC_HIGHEST_BASE)
            base = RDC_VALUE_W'(RDC_HIGHEST_BASE);
        else
            base = {{(RDC_VALUE_W-RDC_RADIX_W){1'b0}}, reg_radix};
        if (v[RDC_VALUE_W-1])
            mag = (v == {1'b1, {(RDC_VALUE_W-1){1'b0}}}) ? {1'b0, {(RDC_VALUE_W-1){1'b1}}} : -v;
        else
            mag = v;
        count = 0;
        do
        begin
            rem = mag % base;
            mag = mag / base;
            if (count < RDC_MAX_DIGITS)
            begin
                digits[count] = rem[RDC_RADIX_W-1:0];
                count++;
            end
        end
        while (mag != 0);
        if (v[RDC_VALUE_W-1])
        begin
            c.code = RDC_CHAR_MINUS;
            c.last = 1'b0;
            chars_due.push_back(c);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            d_ext = {{(RDC_CHAR_W-RDC_RADIX_W){1'b0}}, digits[i]};
            if (d_ext < DECIMAL_DIGITS)
                c.code = RDC_CHAR_ZERO + d_ext;
            else
                c.code = RDC_CHAR_A + d_ext - RDC_CHAR_W'(DECIMAL_DIGITS);
            c.last = (i == 0);
            chars_due.push_back(c);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_proc
        char_t want;
        if (!rst_n)
        begin
            radix_copy = RDC_RADIX_W'(RDC_RADIX_RESET);
            chars_due.delete();
            outstanding <= 0;
            fail_count = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (chars_due.size() == 0)
                begin
                    $error("character: none pending, got %h", character);
                    fail_count++;
                end
                else
                begin
                    want = chars_due.pop_front();
                    if (character !== want.code)
                    begin
                        $error("character: expected %h, got %h", want.code, character);
                        fail_count++;
                    end
                    if (last_char !== want.last)
                    begin
                        $error("last_char: expected %b, got %b", want.last, last_char);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                radix_copy = cfg_data;
            if (start && !busy)
                spell_value(value, radix_copy);
            outstanding <= chars_due.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the radix digit converter testbench: clock, reset, directed and random
// values over several bases, watchdog and verdict. Depends on rdc_pkg,
// radix_digit_converter and rdc_char_checker.
module testbench;
    import rdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 48;
    localparam logic signed [RDC_VALUE_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [RDC_VALUE_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [RDC_VALUE_W-1:0] value;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [RDC_RADIX_W-1:0]        cfg_data;
    logic                          strobe;
    logic [RDC_CHAR_W-1:0]         character;
    logic                          last_char;
    int                            outstanding;
    int                            fail_count;
    int                            idle_cycles;
    logic                          burst;
    logic [RDC_RADIX_W-1:0]        phase_radix [8];

    radix_digit_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .character (character),
        .last_char (last_char)
    );

    rdc_char_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .character   (character),
        .last_char   (last_char),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_value(input logic [RDC_VALUE_W-1:0] v);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // hold the sender until every pending character has come out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy) @(posedge clk);
    endtask

    task automatic set_radix(input logic [RDC_RADIX_W-1:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [RDC_VALUE_W-1:0] random_value();
        logic [RDC_VALUE_W-1:0] v;
        int                     k;
        case ($urandom_range(0, 4))
            0: v = {$urandom, $urandom};
            1: v = RDC_VALUE_W'($urandom_range(0, 2000));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = '0;
                    default: v = RDC_VALUE_W'(1);
                endcase
            end
            3:
            begin
                k = $urandom_range(0, 62);
                v = (64'd1 << k) - RDC_VALUE_W'($urandom_range(0, 2)) + 64'd1;
            end
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        value       <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        idle_cycles <= 0;
        burst        = 1'b0;
        phase_radix  = '{6'd2, 6'd36, 6'd10, 6'd0, 6'd63, 6'd1, 6'd16, 6'd8};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(VAL_MAX);
        send_value(VAL_MIN);
        send_value(-VAL_MAX);
        send_value(64'h0123_4567_89AB_CDEF);
        send_value(64'hFEDC_BA98_7654_3210);
        set_radix(6'd2);
        send_value(VAL_MAX);
        send_value(VAL_MIN);
        send_value(0);
        send_value(-2);
        set_radix(6'd36);
        send_value(VAL_MAX);
        send_value(VAL_MIN);
        send_value(35);
        send_value(36);
        send_value(-1295);
        set_radix(6'd0);
        send_value(5);
        set_radix(6'd1);
        send_value(-6);
        set_radix(6'd37);
        send_value(71);
        set_radix(6'd63);
        send_value(VAL_MAX);
        set_radix(6'd10);
        send_value(VAL_MAX);
        send_value(VAL_MIN);
        send_value(9);

        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
                phase_radix[p] = RDC_RADIX_W'($urandom_range(0, 63));
            set_radix(phase_radix[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 12 == 0)
                    burst = (p % 3 == 0) || ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 30) == 0)
                    drain();
                send_value(random_value());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
